>>> rtl/mtet_pkg.sv
// Shared types, widths and codes for the multi-turn encoder tracker.
// Used by mtet_cfg, mtet_step, the top level and the checker; no dependencies.
`default_nettype none

package mtet_pkg;

   // field widths
   localparam int unsigned COUNT_W    = 13;                   // single-turn count
   localparam int unsigned TURN_W     = 16;                   // rotor turn counter
   localparam int unsigned OFFSET_W   = 16;                   // zero offset
   localparam int unsigned TARGET_W   = 29;                   // set-angle target
   localparam int unsigned MULTI_W    = 30;                   // multi-turn result
   localparam int unsigned OP_W       = 2;
   localparam int unsigned HGR_W      = 14;                   // half gear ratio
   localparam int unsigned MAXT_W     = 15;                   // upper turn clamp
   localparam int unsigned MINT_W     = 16;                   // lower turn clamp
   localparam int unsigned STEP_W     = 18;                   // turns before clamp

   // one revolution of the encoder
   localparam int unsigned COUNTS_PER_REV = 1 << COUNT_W;
   localparam int unsigned HALF_REV       = COUNTS_PER_REV / 2;

   // stream widths, packed to whole bytes
   localparam int unsigned REQ_BITS  = COUNT_W + TARGET_W;
   localparam int unsigned REQ_W     = ((REQ_BITS + 7) / 8) * 8;
   localparam int unsigned RSP_BITS  = MULTI_W + TURN_W;
   localparam int unsigned RSP_W     = ((RSP_BITS + 7) / 8) * 8;

   // configuration port
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_SPEED_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ABSOLUTE_FORMAT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_GEAR_RATIO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_TURNS       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_TURNS       = 3'd4;

   // operation codes
   localparam logic [OP_W-1:0] OP_CAPTURE   = 2'd0;
   localparam logic [OP_W-1:0] OP_SAMPLE    = 2'd1;
   localparam logic [OP_W-1:0] OP_SET_ANGLE = 2'd2;

   // register reset values
   localparam logic [HGR_W-1:0]         HGR_RESET  = 14'd9;
   localparam logic [MAXT_W-1:0]        MAXT_RESET = 15'h7fff;
   localparam logic signed [MINT_W-1:0] MINT_RESET = 16'sh8000;

   typedef struct packed {
      logic                     speed_mode;
      logic                     absolute_format;
      logic [HGR_W-1:0]         half_gear_ratio;
      logic [MAXT_W-1:0]        max_turns;
      logic signed [MINT_W-1:0] min_turns;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_W-1:0]         last_count;
      logic signed [OFFSET_W-1:0] zero_offset;
      logic signed [TURN_W-1:0]   rev_turns;
   } track_type;

   typedef struct packed {
      logic [OP_W-1:0]            operation;
      logic [COUNT_W-1:0]         encoder_count;
      logic signed [TARGET_W-1:0] target_count;
   } item_type;

endpackage

`default_nettype wire

>>> rtl/mtet_cfg.sv
// Configuration register file for the multi-turn encoder tracker.
// Depends on mtet_pkg for register indexes, widths and reset values.
`default_nettype none

module mtet_cfg (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [mtet_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mtet_pkg::CSR_DATA_W-1:0] csr_wdata,
   output mtet_pkg::cfg_type                    cfg
);
   import mtet_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register decode; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_SPEED_MODE:      cfg_in.speed_mode      = csr_wdata[0];
            REG_ABSOLUTE_FORMAT: cfg_in.absolute_format = csr_wdata[0];
            REG_HALF_GEAR_RATIO: cfg_in.half_gear_ratio = csr_wdata[HGR_W-1:0];
            REG_MAX_TURNS:       cfg_in.max_turns       = csr_wdata[MAXT_W-1:0];
            REG_MIN_TURNS:       cfg_in.min_turns       = $signed(csr_wdata[MINT_W-1:0]);
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_mode      <= 1'b0;
         cfg_ff.absolute_format <= 1'b0;
         cfg_ff.half_gear_ratio <= HGR_RESET;
         cfg_ff.max_turns       <= MAXT_RESET;
         cfg_ff.min_turns       <= MINT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/mtet_step.sv
// Next-state and result logic for one tracker operation.
// Depends on mtet_pkg for the item, state and configuration structs.
`default_nettype none

module mtet_step (
   input  wire mtet_pkg::cfg_type                    cfg,
   input  wire mtet_pkg::track_type                  cur,
   input  wire mtet_pkg::item_type                   item,
   output mtet_pkg::track_type                       nxt,
   output logic signed [mtet_pkg::MULTI_W-1:0]       multi_turn_count,
   output logic signed [mtet_pkg::TURN_W-1:0]        turn_count
);
   import mtet_pkg::*;

   localparam logic signed [COUNT_W:0] HALF_REV_S = (COUNT_W + 1)'(HALF_REV);
   localparam logic [TARGET_W-1:0]     REM_BIAS   = TARGET_W'(COUNTS_PER_REV - 1);

   // sample path
   logic signed [COUNT_W:0]    diff_dn;
   logic signed [COUNT_W:0]    diff_up;
   logic signed [STEP_W-1:0]   turns_stepped;
   logic signed [STEP_W-1:0]   turns_wrapped;
   logic signed [STEP_W-1:0]   turns_free;
   logic signed [STEP_W-1:0]   turns_clamped;
   logic signed [STEP_W-1:0]   half_s;
   logic signed [STEP_W-1:0]   max_s;
   logic signed [STEP_W-1:0]   min_s;
   logic signed [OFFSET_W:0]   ecd_s;
   logic signed [OFFSET_W:0]   off_s;
   // set-angle path
   logic signed [TARGET_W-1:0] biased;
   logic signed [TURN_W-1:0]   quot;
   logic signed [TARGET_W-1:0] rem_w;
   logic signed [OFFSET_W-1:0] rem_s;
   // result
   logic [COUNT_W-1:0]         cnt;
   logic signed [MULTI_W-1:0]  res_turns;

   // wrap detection on the single-turn count
   assign diff_dn = $signed({1'b0, cur.last_count}) - $signed({1'b0, item.encoder_count});
   assign diff_up = $signed({1'b0, item.encoder_count}) - $signed({1'b0, cur.last_count});

   always_comb begin
      turns_stepped = STEP_W'(cur.rev_turns);
      if (diff_dn > HALF_REV_S) begin
         turns_stepped = STEP_W'(cur.rev_turns) + STEP_W'(1);
      end else if (diff_up > HALF_REV_S) begin
         turns_stepped = STEP_W'(cur.rev_turns) - STEP_W'(1);
      end
   end

   // absolute format wraps within plus or minus half the gear ratio
   assign half_s = $signed({{(STEP_W-HGR_W){1'b0}}, cfg.half_gear_ratio});
   assign ecd_s  = $signed({{(OFFSET_W+1-COUNT_W){1'b0}}, item.encoder_count});
   assign off_s  = $signed({cur.zero_offset[OFFSET_W-1], cur.zero_offset});

   always_comb begin
      turns_wrapped = turns_stepped;
      if (turns_stepped >= half_s && ecd_s > off_s) begin
         turns_wrapped = -half_s;
      end else if (turns_stepped <= -half_s && ecd_s < off_s) begin
         turns_wrapped = half_s;
      end
   end

   assign turns_free = cfg.speed_mode      ? '0 :
                       cfg.absolute_format ? turns_wrapped : turns_stepped;

   // clamp, upper limit first
   assign max_s = $signed({{(STEP_W-MAXT_W){1'b0}}, cfg.max_turns});
   assign min_s = STEP_W'(cfg.min_turns);

   always_comb begin
      if (turns_free > max_s) begin
         turns_clamped = max_s;
      end else if (turns_free < min_s) begin
         turns_clamped = min_s;
      end else begin
         turns_clamped = turns_free;
      end
   end

   // truncating divide by one revolution: bias negatives, then shift
   assign biased = item.target_count +
                   (item.target_count[TARGET_W-1] ? $signed(REM_BIAS) : $signed(TARGET_W'(0)));
   assign quot   = $signed(biased[TARGET_W-1 -: TURN_W]);
   assign rem_w  = item.target_count - $signed({quot, {COUNT_W{1'b0}}});
   assign rem_s  = $signed(rem_w[OFFSET_W-1:0]);

   // state update per operation
   always_comb begin
      nxt = cur;
      cnt = cur.last_count;
      case (item.operation)
         OP_CAPTURE: begin
            nxt.zero_offset = $signed(OFFSET_W'(item.encoder_count));
            nxt.last_count  = item.encoder_count;
            cnt             = item.encoder_count;
         end
         OP_SAMPLE: begin
            if (cfg.speed_mode) begin
               nxt.zero_offset = $signed(OFFSET_W'(item.encoder_count));
            end
            nxt.last_count  = item.encoder_count;
            nxt.rev_turns   = turns_clamped[TURN_W-1:0];
            cnt             = item.encoder_count;
         end
         OP_SET_ANGLE: begin
            nxt.rev_turns   = quot;
            nxt.zero_offset = $signed(OFFSET_W'(cur.last_count)) - rem_s;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   // turns times revolution plus count minus offset, modulo the result width
   assign res_turns        = MULTI_W'($signed({nxt.rev_turns, {COUNT_W{1'b0}}}));
   assign multi_turn_count = res_turns + $signed(MULTI_W'(cnt)) - MULTI_W'(nxt.zero_offset);
   assign turn_count       = nxt.rev_turns;

endmodule

`default_nettype wire

>>> rtl/multi_turn_encoder_tracker.sv
// Top level of the multi-turn encoder tracker: input register, state, result register.
// Depends on mtet_pkg, mtet_cfg and mtet_step.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+---------------------------------------------
//  req      | in        | tvalid / tready  | tuser operation, tdata count and target
//  rsp      | out       | tvalid / tready  | tdata multi_turn_count and turn_count
//  csr      | in        | write enable     | index 0..4, data up to 16 bits
//
// One item per cycle sustained while rsp_tready stays high; an item passes the input
// register and then the result register. The tracker state updates as an item leaves
// the input register, so the next item sees the new state. Reset clears both pipeline
// valids, the state and the registers to their defaults. A stalled rsp side holds the
// result and stops the input register; req_tready drops only while both stages are full.
`default_nettype none

module multi_turn_encoder_tracker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [mtet_pkg::REQ_W-1:0]      req_tdata,  // encoder_count, target_count
   input  wire logic [mtet_pkg::OP_W-1:0]       req_tuser,  // operation
   // response stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [mtet_pkg::RSP_W-1:0]           rsp_tdata,  // multi_turn_count, turn_count
   // configuration writes
   input  wire logic                            csr_we,
   input  wire logic [mtet_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mtet_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mtet_pkg::*;

   cfg_type                    cfg;
   logic                       in_valid_ff;
   logic                       in_valid_in;
   item_type                   in_item_ff;
   track_type                  track_ff;
   track_type                  track_in;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic [RSP_W-1:0]           out_data_ff;
   logic                       advance;
   logic signed [MULTI_W-1:0]  multi_turn_count;
   logic signed [TURN_W-1:0]   turn_count;

   mtet_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mtet_step u_step (
      .cfg              (cfg),
      .cur              (track_ff),
      .item             (in_item_ff),
      .nxt              (track_in),
      .multi_turn_count (multi_turn_count),
      .turn_count       (turn_count)
   );

   // handshake: the input register moves on whenever the result register is free
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   // control and tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         track_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            track_ff <= track_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.operation     <= req_tuser;
         in_item_ff.encoder_count <= req_tdata[COUNT_W-1:0];
         in_item_ff.target_count  <= $signed(req_tdata[COUNT_W +: TARGET_W]);
      end
      if (advance) begin
         out_data_ff <= RSP_W'({turn_count, multi_turn_count});
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

>>> rtl/mtet_checker.sv
// Port-level checks for the multi-turn encoder tracker, bound to the top level.
// Depends on mtet_pkg for port widths.
`default_nettype none

module mtet_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [mtet_pkg::RSP_W-1:0]      rsp_tdata
);
   import mtet_pkg::*;

   // a stalled result stays and holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transfer dropped or changed while stalled");

   // nothing is shown straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // input stalls only while a result waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req side stalled with result register empty");

   // an accepted item has a result showing once through the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("no result two cycles after a req transfer");

endmodule

bind multi_turn_encoder_tracker mtet_checker u_mtet_checker (.*);

`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for multi_turn_encoder_tracker: a directed table, then random traffic
// over several register settings. Needs mtet_pkg and the rtl top level; responses are
// checked against a tracker model kept inside the bench.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mtet_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam longint REV  = COUNTS_PER_REV;
   localparam longint HALF = HALF_REV;
   localparam longint TARGET_SPAN = 268435455;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 250;
   localparam int HOLD_AFTER     = 350;
   localparam int MAX_SHOWN      = 10;
   localparam int TAIL_CYCLES    = 8;

   typedef struct packed {
      logic [MULTI_W-1:0] multi;
      logic [TURN_W-1:0]  turns;
   } position_type;

   typedef struct {
      logic [OP_W-1:0] op;
      int              ecd;
      int              tgt;
      bit              fixed;
      int              multi;
      int              turns;
   } stim_row_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;
   logic [OP_W-1:0]    req_tuser  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // bench copy of the registers and tracker state
   cfg_type   track_cfg;
   track_type trk;

   position_type pending_pos[$];
   int        fail_count     = 0;
   int        idle_cycles    = 0;
   int        accepted_items = 0;
   int        stim_last      = 0;

   // directed stimulus; fixed rows carry a response readable at a glance
   stim_row_type directed_rows [23] = '{
      // wrap down and up across zero from reset
      '{OP_SAMPLE,    0,          0,          1'b1, 0,          0},
      '{OP_SAMPLE,    8191,       0,          1'b1, -1,         -1},
      '{OP_SAMPLE,    0,          0,          1'b1, 0,          0},
      '{OP_CAPTURE,   8191,       0,          1'b1, 0,          0},
      // jumps of exactly half a revolution and one count more
      '{OP_SAMPLE,    4095,       0,          1'b0, 0,          0},
      '{OP_SAMPLE,    0,          0,          1'b0, 0,          0},
      '{OP_SAMPLE,    4097,       0,          1'b0, 0,          0},
      '{OP_CAPTURE,   4097,       -1,         1'b1, -8192,      -1},
      // target extremes and turn counter pinned at the clamps
      '{OP_SET_ANGLE, 0,          268435455,  1'b1, 268435455,  32767},
      '{OP_SAMPLE,    0,          0,          1'b0, 0,          0},
      '{OP_SET_ANGLE, 0,          -268435455, 1'b1, -268435455, -32767},
      '{OP_SAMPLE,    5000,       0,          1'b0, 0,          0},
      '{OP_SAMPLE,    2000,       0,          1'b0, 0,          0},
      '{OP_SAMPLE,    7000,       0,          1'b0, 0,          0},
      // unused code leaves the state alone
      '{OP_UNUSED,    8191,       -268435455, 1'b0, 0,          0},
      // truncation of the turn count towards zero
      '{OP_SET_ANGLE, 0,          -1,         1'b1, -1,         0},
      '{OP_SET_ANGLE, 0,          8191,       1'b1, 8191,       0},
      '{OP_SET_ANGLE, 0,          -8192,      1'b1, -8192,      -1},
      '{OP_SET_ANGLE, 0,          8192,       1'b1, 8192,       1},
      '{OP_SET_ANGLE, 8191,       0,          1'b1, 0,          0},
      '{OP_CAPTURE,   0,          268435455,  1'b1, 0,          0},
      '{OP_UNUSED,    0,          0,          1'b0, 0,          0},
      '{OP_SAMPLE,    8191,       0,          1'b0, 0,          0}
   };

   multi_turn_encoder_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // encoder_count, target_count
      .req_tuser  (req_tuser),   // operation
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // multi_turn_count, turn_count
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // advance the tracker by one item and return the response it gives
   function automatic position_type track_position(input item_type it);
      longint    ecd, last, ofs, t, h, tgt, q, cnt, maxt, mint, turns_now, ofs_now;
      position_type p;
      ecd  = it.encoder_count;
      tgt  = $signed(it.target_count);
      last = trk.last_count;
      ofs  = $signed(trk.zero_offset);
      maxt = track_cfg.max_turns;
      mint = $signed(track_cfg.min_turns);
      cnt  = last;
      case (it.operation)
         OP_CAPTURE: begin
            trk.zero_offset = OFFSET_W'(ecd);
            trk.last_count  = COUNT_W'(ecd);
            cnt = ecd;
         end
         OP_SAMPLE: begin
            t = $signed(trk.rev_turns);
            if (track_cfg.speed_mode) begin
               t = 0;
               trk.zero_offset = OFFSET_W'(ecd);
            end else begin
               // a jump of more than half a revolution is a wrap
               if (last - ecd > HALF) t++;
               else if (ecd - last > HALF) t--;
               if (track_cfg.absolute_format) begin
                  h = track_cfg.half_gear_ratio;
                  if (t > h - 1 && ecd > ofs) t = -h;
                  else if (t < 1 - h && ecd < ofs) t = h;
               end
            end
            trk.last_count = COUNT_W'(ecd);
            // upper limit is tested first
            if (t > maxt) t = maxt;
            else if (t < mint) t = mint;
            trk.rev_turns = TURN_W'(t);
            cnt = ecd;
         end
         OP_SET_ANGLE: begin
            q = tgt / REV;
            if (q > 32767) q = 32767;
            else if (q < -32768) q = -32768;
            trk.rev_turns   = TURN_W'(q);
            trk.zero_offset = OFFSET_W'(last - (tgt - q * REV));
         end
         default: ;
      endcase
      turns_now = $signed(trk.rev_turns);
      ofs_now   = $signed(trk.zero_offset);
      p.multi   = MULTI_W'(turns_now * REV + cnt - ofs_now);
      p.turns   = trk.rev_turns;
      return p;
   endfunction

   // one random item; most are samples that step round the encoder from the last count
   function automatic item_type random_item();
      item_type it;
      int       pick, delta;
      pick = $urandom_range(99);
      it.encoder_count = COUNT_W'($urandom);
      it.target_count  = TARGET_W'(longint'($urandom_range(2 * TARGET_SPAN)) - TARGET_SPAN);
      if (pick < 70) begin
         it.operation = OP_SAMPLE;
         case ($urandom_range(3))
            0, 1:    delta = int'($urandom_range(6000)) - 3000;
            2:       delta = int'($urandom_range(2)) + 4095;
            default: delta = -(int'($urandom_range(2)) + 4095);
         endcase
         it.encoder_count = COUNT_W'(stim_last + delta);
      end else if (pick < 80) begin
         it.operation = OP_CAPTURE;
      end else if (pick < 90) begin
         it.operation = OP_SET_ANGLE;
         if ($urandom_range(1))
            it.target_count = TARGET_W'(int'($urandom_range(400000)) - 200000);
      end else if (pick < 96) begin
         // sample with an arbitrary count
         it.operation = OP_SAMPLE;
      end else begin
         it.operation = OP_UNUSED;
      end
      return it;
   endfunction

   // offer one item and record its expected response on transfer
   task automatic send_item(input item_type it, input bit fixed, input position_type fixed_pos);
      position_type p;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= it.operation;
      req_tdata  <= REQ_W'({it.target_count, it.encoder_count});
      do @(posedge clock); while (!req_tready);
      p = track_position(it);
      pending_pos.push_back(fixed ? fixed_pos : p);
      accepted_items++;
      if (it.operation == OP_CAPTURE || it.operation == OP_SAMPLE)
         stim_last = it.encoder_count;
   endtask

   task automatic idle_req(input int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   // stop offering and wait for every response
   task automatic settle();
      idle_req(1);
      while (pending_pos.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_SPEED_MODE:      track_cfg.speed_mode      = val[0];
         REG_ABSOLUTE_FORMAT: track_cfg.absolute_format = val[0];
         REG_HALF_GEAR_RATIO: track_cfg.half_gear_ratio = val[HGR_W-1:0];
         REG_MAX_TURNS:       track_cfg.max_turns       = val[MAXT_W-1:0];
         REG_MIN_TURNS:       track_cfg.min_turns       = val[MINT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input bit speed, input bit absf, input int hgr,
                                 input int maxt, input int mint);
      csr_write(REG_SPEED_MODE, CSR_DATA_W'(speed));
      csr_write(REG_ABSOLUTE_FORMAT, CSR_DATA_W'(absf));
      csr_write(REG_HALF_GEAR_RATIO, CSR_DATA_W'(hgr));
      csr_write(REG_MAX_TURNS, CSR_DATA_W'(maxt));
      csr_write(REG_MIN_TURNS, CSR_DATA_W'(mint));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // random items in bursts; steady drops the gaps between bursts
   task automatic drive_traffic(input int n_items, input bit steady);
      int       sent, burst;
      item_type it;
      sent  = 0;
      burst = 0;
      while (sent < n_items) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 24);
            if (!steady) idle_req($urandom_range(0, 8));
         end
         it = random_item();
         send_item(it, 1'b0, '0);
         burst--;
         if (it.operation != OP_UNUSED) sent++;
      end
      settle();
   endtask

   // main sequence
   initial begin
      item_type     it;
      position_type want;
      track_cfg = '{1'b0, 1'b0, HGR_RESET, MAXT_RESET, MINT_RESET};
      trk       = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         it.operation     = directed_rows[i].op;
         it.encoder_count = COUNT_W'(directed_rows[i].ecd);
         it.target_count  = TARGET_W'(directed_rows[i].tgt);
         want.multi       = MULTI_W'(directed_rows[i].multi);
         want.turns       = TURN_W'(directed_rows[i].turns);
         send_item(it, directed_rows[i].fixed, want);
      end
      settle();

      drive_traffic(150, 1'b0);
      apply_settings(1'b1, 1'b0, 9, 32767, -32768);
      drive_traffic(100, 1'b0);
      apply_settings(1'b0, 1'b1, 2, 32767, -32768);
      drive_traffic(150, 1'b0);
      apply_settings(1'b0, 1'b1, 0, 32767, -32768);
      drive_traffic(100, 1'b1);
      apply_settings(1'b0, 1'b1, 16383, 5, -5);
      drive_traffic(150, 1'b0);
      apply_settings(1'b1, 1'b1, 16383, 0, 0);
      drive_traffic(60, 1'b0);
      apply_settings(1'b0, 1'b0, 9, 0, 0);
      drive_traffic(90, 1'b0);
      apply_settings(1'b0, 1'b0, 9, 32767, -32768);
      drive_traffic(150, 1'b0);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   // response side: random stall windows, and one long hold-off to fill the block
   initial begin
      int mode, span;
      bit held;
      held = 1'b0;
      forever begin
         mode = $urandom_range(3);
         span = $urandom_range(8, 64);
         for (int k = 0; k < span; k++) begin
            @(negedge clock);
            if (!held && accepted_items >= HOLD_AFTER) begin
               held = 1'b1;
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
            end
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(3) != 0);
               2:       rsp_tready <= ($urandom_range(3) == 0);
               default: rsp_tready <= ((k % 4) != 3);
            endcase
         end
      end
   end

   // compare each response transfer with the oldest expected position
   always @(posedge clock) begin
      position_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.multi = rsp_tdata[MULTI_W-1:0];
         got.turns = rsp_tdata[MULTI_W +: TURN_W];
         if (pending_pos.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
               $display("unexpected response: multi %0d turns %0d",
                        $signed(got.multi), $signed(got.turns));
         end else begin
            want = pending_pos.pop_front();
            if (got.multi !== want.multi || got.turns !== want.turns) begin
               fail_count++;
               if (fail_count <= MAX_SHOWN)
                  $display("response mismatch: multi exp %0d got %0d, turns exp %0d got %0d",
                           $signed(want.multi), $signed(got.multi),
                           $signed(want.turns), $signed(got.turns));
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

endmodule
